// ===== rtl/oidt_pkg.sv =====
// Shared types and constants for the object id table.
// Used by every module of the block but oidt_ram; depends on nothing.
package oidt_pkg;

    localparam int KEY_W    = 32;
    localparam int CODE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam int          TABLE_ENTRIES_DEF = 64;
    localparam logic [31:0] ID_LIMIT_RESET    = 32'hFEFF_FFFF;
    localparam logic [31:0] COUNTER_START     = 32'd2;

    localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [KEY_W-1:0]  key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the accepted word
        logic clr_wr;    // write an empty entry at the sweep address
        logic rd_en;     // read the entry at the scan address
        logic commit;    // perform the table write the operation calls for
        logic out_load;  // form the result and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
    } sts_t;

endpackage

// ===== rtl/oidt_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; depends on nothing.
module oidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/oidt_ctrl.sv =====
// Sequencing state machine of the object id table: clearing sweep, entry scan,
// table write and result hand-off. Depends on oidt_pkg.
module oidt_ctrl #(
    parameter int TABLE_ENTRIES = oidt_pkg::TABLE_ENTRIES_DEF,
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  oidt_pkg::sts_t sts,
    output oidt_pkg::cmd_t cmd,
    output logic [AW-1:0]  addr
);

    import oidt_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_DRAIN    = 3'd4;
    localparam logic [2:0] S_DECIDE   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          out_valid_reg, out_valid_next;
    logic          addr_last;
    logic          out_free;

    assign addr_last = (addr_reg == AW'(TABLE_ENTRIES - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign addr      = addr_reg;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                addr_next  = addr_reg + AW'(1);
                if (addr_last)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                addr_next = '0;
                if (sts.kind == KIND_NEW)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_last)
                begin
                    addr_next  = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/oidt_dp.sv =====
// Datapath of the object id table: entry memory, match and free-slot tracking,
// id counter, limit register and result register. Depends on oidt_pkg, oidt_ram.
module oidt_dp #(
    parameter int TABLE_ENTRIES = oidt_pkg::TABLE_ENTRIES_DEF,
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  oidt_pkg::cmd_t                  cmd,
    output oidt_pkg::sts_t                  sts,
    input  logic [AW-1:0]                   addr,
    input  logic [oidt_pkg::KIND_W-1:0]     in_kind,
    input  logic [oidt_pkg::KEY_W-1:0]      in_key,
    input  logic [oidt_pkg::CODE_W-1:0]     in_code,
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_data,
    output logic [oidt_pkg::STATUS_W-1:0]   out_status,
    output logic [oidt_pkg::SLOT_W-1:0]     out_slot,
    output logic [oidt_pkg::CODE_W-1:0]     out_iface,
    output logic [oidt_pkg::KEY_W-1:0]      out_fresh
);

    import oidt_pkg::*;

    logic [KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CODE_W-1:0] code_reg;

    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;
    entry_t            rd_entry;

    logic              hit_reg, hit_next;
    logic [AW-1:0]     hit_idx_reg, hit_idx_next;
    logic [CODE_W-1:0] hit_code_reg, hit_code_next;
    logic              free_reg, free_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;

    logic [31:0]       limit_reg;
    logic [31:0]       counter_reg, counter_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CODE_W-1:0]   iface_reg, iface_next;
    logic [KEY_W-1:0]    fresh_reg, fresh_next;

    logic              we;
    logic [AW-1:0]     waddr;
    entry_t            wdata;
    logic              do_insert, do_remove;
    logic [SLOT_W+AW-1:0] slot_ext;

    oidt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (addr),
        .rdata (rd_entry)
    );

    assign sts.kind = kind_reg;

    assign do_insert = (kind_reg == KIND_INSERT) && !hit_reg && free_reg;
    assign do_remove = (kind_reg == KIND_REMOVE) && hit_reg;

    // Table write: clearing sweep, insert into the first free slot, or removal.
    always_comb
    begin
        we    = 1'b0;
        waddr = addr;
        wdata = '0;
        if (cmd.clr_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.commit && do_insert)
        begin
            we          = 1'b1;
            waddr       = free_idx_reg;
            wdata.valid = 1'b1;
            wdata.code  = code_reg;
            wdata.key   = key_reg;
        end
        else if (cmd.commit && do_remove)
        begin
            we    = 1'b1;
            waddr = hit_idx_reg;
        end
    end

    // Scan tracking: the first valid match and the lowest empty slot.
    always_comb
    begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_code_next = hit_code_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        if (cmd.load)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_entry.valid && (rd_entry.key == key_reg) && !hit_reg)
            begin
                hit_next      = 1'b1;
                hit_idx_next  = rd_idx_reg;
                hit_code_next = rd_entry.code;
            end
            if (!rd_entry.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx_reg;
            end
        end
    end

    assign slot_ext = (SLOT_W + AW)'(free_idx_reg);

    // Result formation and id counter update.
    always_comb
    begin
        status_next  = status_reg;
        slot_next    = slot_reg;
        iface_next   = iface_reg;
        fresh_next   = fresh_reg;
        counter_next = counter_reg;
        if (cmd.out_load)
        begin
            status_next = ST_OK;
            slot_next   = '0;
            iface_next  = '0;
            fresh_next  = '0;
            case (kind_reg)
                KIND_NEW:
                begin
                    fresh_next = counter_reg;
                    if (counter_reg < limit_reg)
                    begin
                        counter_next = counter_reg + 32'd1;
                    end
                end
                KIND_INSERT:
                begin
                    if (hit_reg)
                    begin
                        status_next = ST_DUP;
                    end
                    else if (!free_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        slot_next = slot_ext[SLOT_W-1:0];
                    end
                end
                KIND_LOOKUP:
                begin
                    if (hit_reg)
                    begin
                        iface_next = hit_code_reg;
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                    end
                end
                default:
                begin
                    if (!hit_reg)
                    begin
                        status_next = ST_MISSING;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            limit_reg   <= ID_LIMIT_RESET;
            counter_reg <= COUNTER_START;
        end
        else
        begin
            rd_vld_reg  <= cmd.rd_en;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            counter_reg <= counter_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= addr;
        hit_idx_reg  <= hit_idx_next;
        hit_code_reg <= hit_code_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        iface_reg    <= iface_next;
        fresh_reg    <= fresh_next;
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            key_reg  <= in_key;
            code_reg <= in_code;
        end
    end

    assign out_status = status_reg;
    assign out_slot   = slot_reg;
    assign out_iface  = iface_reg;
    assign out_fresh  = fresh_reg;

endmodule

// ===== rtl/object_id_table.sv =====
// Object id table: new-id, insert, lookup and remove on a table of id entries.
// New-id goes from dispatch straight to the result register; the others first scan the
// table through the single read port, one entry per cycle, then drain and decide.
// One word is worked on at a time; the next word is taken while the result still waits,
// but its own result is not loaded until the result side has taken the last one.
// After reset a clearing sweep writes an empty entry to every slot of the table.
module object_id_table #(
    parameter int TABLE_ENTRIES = oidt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [oidt_pkg::IN_TDATA_W-1:0]     s_tdata,  // obj_id[31:0], iface_code[39:32]
    input  logic [oidt_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [oidt_pkg::OUT_TDATA_W-1:0]    m_tdata,  // slot[5:0], found_iface[13:6],
                                                          // fresh_id[45:14], zero[47:46]
    output logic [oidt_pkg::STATUS_W-1:0]       m_tuser,  // status[1:0]
    // Configuration write channel for the id limit.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data
);

    import oidt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    cmd_t            cmd;
    sts_t            sts;
    logic [AW-1:0]   addr;
    logic [SLOT_W-1:0] out_slot;
    logic [CODE_W-1:0] out_iface;
    logic [KEY_W-1:0]  out_fresh;

    // Always ready. The user must write the limit register only while idle; not enforced.
    assign cfg_ready = 1'b1;

    // The controller walks the sweep and scan addresses and issues commands;
    // the datapath holds the table and forms each result word.
    oidt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr)
    );

    oidt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .addr       (addr),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_code    (s_tdata[KEY_W+CODE_W-1:KEY_W]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_iface  (out_iface),
        .out_fresh  (out_fresh)
    );

    // Result word packing, lowest field first, padded with zeros to whole bytes.
    assign m_tdata = {2'b00, out_fresh, out_iface, out_slot};

endmodule

// ===== dv/object_id_table_chk.sv =====
`timescale 1ns / 100ps
// Checker for the object id table: watches the input, result and limit channels,
// keeps its own copy of the table and the id counter, and compares every result word.
// Depends on oidt_pkg for field widths, operation codes and status codes.
module object_id_table_chk (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [oidt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [oidt_pkg::KIND_W-1:0]      s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [oidt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [oidt_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [31:0]                      cfg_data,
    output int                               fail_count,
    output int                               outstanding
);

    import oidt_pkg::*;

    localparam int ENTRIES = TABLE_ENTRIES_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [CODE_W-1:0]   found_iface;
        logic [KEY_W-1:0]    fresh_id;
    } table_reply_t;

    logic [KEY_W-1:0]  tbl_key  [ENTRIES];
    logic [CODE_W-1:0] tbl_code [ENTRIES];
    logic              tbl_used [ENTRIES];
    logic [31:0]       next_id;
    logic [31:0]       id_ceiling;
    table_reply_t      reply_q[$];
    int                mismatches;

    assign fail_count = mismatches;

    function automatic int find_entry(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_used[i] && tbl_key[i] == key)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one operation to the shadow table and returns the reply it must produce.
    function automatic table_reply_t apply_op(input logic [KIND_W-1:0] kind,
                                              input logic [KEY_W-1:0]  key,
                                              input logic [CODE_W-1:0] code);
        table_reply_t r;
        int           hit;
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        case (kind)
            KIND_NEW:
            begin
                r.fresh_id = next_id;
                if (next_id < id_ceiling)
                begin
                    next_id = next_id + 32'd1;
                end
            end
            KIND_INSERT:
            begin
                if (find_entry(key) >= 0)
                begin
                    r.status = ST_DUP;
                end
                else
                begin
                    for (int i = 0; i < ENTRIES && hit < 0; i++)
                    begin
                        if (!tbl_used[i])
                        begin
                            hit = i;
                        end
                    end
                    if (hit < 0)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        tbl_key[hit]  = key;
                        tbl_code[hit] = code;
                        tbl_used[hit] = 1'b1;
                        r.slot        = SLOT_W'(hit);
                    end
                end
            end
            KIND_LOOKUP:
            begin
                hit = find_entry(key);
                if (hit < 0)
                begin
                    r.status = ST_MISSING;
                end
                else
                begin
                    r.found_iface = tbl_code[hit];
                end
            end
            default:
            begin
                hit = find_entry(key);
                if (hit < 0)
                begin
                    r.status = ST_MISSING;
                end
                else
                begin
                    tbl_used[hit] = 1'b0;
                    tbl_key[hit]  = '0;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        table_reply_t seen;
        table_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tbl_key[i]  = '0;
                tbl_code[i] = '0;
                tbl_used[i] = 1'b0;
            end
            next_id     = COUNTER_START;
            id_ceiling  = ID_LIMIT_RESET;
            reply_q.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                id_ceiling = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                reply_q.push_back(apply_op(s_tuser, s_tdata[KEY_W-1:0],
                                           s_tdata[KEY_W +: CODE_W]));
            end
            if (m_tvalid && m_tready)
            begin
                seen = {m_tuser, m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: CODE_W],
                        m_tdata[SLOT_W+CODE_W +: KEY_W]};
                if (reply_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("[%0t] result word with none outstanding: status %0d",
                                 $realtime, seen.status);
                    end
                    mismatches++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (seen != want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] mismatch: status %0d/%0d slot %0d/%0d",
                                     $realtime, want.status, seen.status,
                                     want.slot, seen.slot);
                            $display("    iface %02h/%02h fresh_id %08h/%08h (exp/got)",
                                     want.found_iface, seen.found_iface,
                                     want.fresh_id, seen.fresh_id);
                        end
                        mismatches++;
                    end
                end
            end
            outstanding <= reply_q.size();
        end
    end

endmodule

// ===== dv/object_id_table_tb.sv =====
`timescale 1ns / 100ps
// Top of the object id table testbench: clock, reset, stimulus and the final verdict.
// Depends on oidt_pkg, the object_id_table block and the object_id_table_chk checker.
module object_id_table_tb;

    import oidt_pkg::*;

    // Operation mixes for the random phases.
    typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_COUNT} mix_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // obj_id[31:0], iface_code[39:32]
    logic [KIND_W-1:0]      s_tuser   = '0;   // kind[1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // slot[5:0], found_iface[13:6], fresh_id[45:14]
    logic [STATUS_W-1:0]    m_tuser;          // status[1:0]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [31:0]            cfg_data  = '0;

    int fail_count;
    int outstanding;

    // Burst counters: while one is non-zero that side runs without idling.
    int tx_burst = 0;
    int rx_burst = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    object_id_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    object_id_table_chk i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Idle cycles before the next word: a random gap, with occasional stretches of none.
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Presents one word and returns at the edge that accepts it. The valid is left high,
    // so that a following word with no gap is not preceded by a lowered valid in the
    // same time step.
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] id,
                             input logic [CODE_W-1:0] code);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code, id};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until the checker has seen every result word come back.
    // This is also the point where the sender holds off with no word in flight.
    task automatic wait_drained();
        int spin;
        spin = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && spin < 4000)
        begin
            spin++;
            @(posedge clk);
        end
    endtask

    // Writes the id limit; only called while nothing is in flight.
    task automatic write_limit(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random words. Most ids come from a pool of 80, so that the 64-entry table
    // fills up, duplicates are hit and lookups and removes find their entries; the
    // rest are extremes or fully random ids that exercise every bit.
    task automatic run_phase(input mix_t mix, input int count);
        int                pick;
        int                t_new;
        int                t_ins;
        int                t_look;
        int                r;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  id;
        case (mix)
            MIX_FILL:  begin t_new = 15; t_ins = 70; t_look = 90; end
            MIX_EVEN:  begin t_new = 25; t_ins = 50; t_look = 75; end
            MIX_DRAIN: begin t_new = 15; t_ins = 35; t_look = 60; end
            default:   begin t_new = 50; t_ins = 70; t_look = 85; end
        endcase
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < t_new)
                kind = KIND_NEW;
            else if (pick < t_ins)
                kind = KIND_INSERT;
            else if (pick < t_look)
                kind = KIND_LOOKUP;
            else
                kind = KIND_REMOVE;
            r = $urandom_range(0, 9);
            if (r < 7)
                id = 32'h5A00_0000 | 32'($urandom_range(0, 79));
            else if (r == 7)
                id = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            else
                id = $urandom;
            send_word(kind, id, CODE_W'($urandom_range(0, 255)));
        end
    endtask

    // Result side: before each result word the receiver holds ready low for a drawn
    // number of cycles, then keeps it high until a word has been taken.
    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        forever
        begin
            gap = draw_gap(rx_burst);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A low limit first, so that the counter reaches it within a few new-id words.
        write_limit(32'd5);
        repeat (5) send_word(KIND_NEW, 32'h0, 8'h00);

        // Extremes of id and code, a duplicate, hits and misses, and reuse of the
        // lowest free slot after a remove.
        send_word(KIND_INSERT, 32'h0000_0000, 8'h00);
        send_word(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_word(KIND_INSERT, 32'h0000_0000, 8'h5A);
        send_word(KIND_INSERT, 32'h1234_5678, 8'hA5);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_word(KIND_LOOKUP, 32'h0000_0000, 8'hFF);
        send_word(KIND_LOOKUP, 32'hDEAD_BEEF, 8'h00);
        send_word(KIND_REMOVE, 32'h0000_0000, 8'h00);
        send_word(KIND_REMOVE, 32'h0000_0000, 8'h00);
        send_word(KIND_LOOKUP, 32'h0000_0000, 8'h00);
        send_word(KIND_INSERT, 32'hDEAD_BEEF, 8'h3C);
        send_word(KIND_REMOVE, 32'h1234_5678, 8'h00);
        send_word(KIND_INSERT, 32'h8000_0001, 8'h81);
        send_word(KIND_LOOKUP, 32'h8000_0001, 8'h00);

        // A limit below the running counter: new-id keeps handing out the same id.
        wait_drained();
        write_limit(32'd0);
        repeat (2) send_word(KIND_NEW, 32'hFFFF_FFFF, 8'hFF);

        // Insert-heavy phase that fills the table and runs into the full case.
        run_phase(MIX_FILL, 170);

        wait_drained();
        write_limit(32'hFFFF_FFFF);
        run_phase(MIX_EVEN, 170);

        wait_drained();
        write_limit($urandom);
        run_phase(MIX_DRAIN, 150);

        // Moderate limit in a new-id-heavy phase, so the counter saturates by counting.
        wait_drained();
        write_limit(32'($urandom_range(60, 110)));
        run_phase(MIX_COUNT, 160);

        wait_drained();
        repeat (TABLE_ENTRIES_DEF + 8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: stops a run that hangs, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
